// ===== hw/rtl/mec_pkg.sv =====
// Shared types, constants and width helpers for the escape-time counter.
package mec_pkg;

    // Field widths fixed by the interface.
    localparam int POINT_W      = 32;
    localparam int CFG_W        = 17;
    localparam int COUNT_OUT_W  = 17;

    // Iteration limit after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

    // Escape radius squared, in whole units.
    localparam int ESC_RADIUS_SQ = 4;

    // The multiplier takes the full orbit magnitude times one slice of this many bits.
    localparam int CHUNK_W     = 18;
    localparam int CHUNK_IDX_W = 2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_TEST,
        ST_DONE
    } t_state;

    // Which product the shared multiplier is working on.
    typedef enum logic [1:0] {
        OP_RR,
        OP_II,
        OP_RI
    } t_mul_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   load;
        logic                   step;
        logic                   mul_issue;
        t_mul_op                mul_op;
        logic [CHUNK_IDX_W-1:0] mul_chunk;
        logic                   mul_first;
        logic                   mul_last;
        logic                   out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_limit;
        logic escaped;
    } t_dp_status;

    // Orbit width: eight integer bits above the fraction, never narrower than a point.
    function automatic int orbit_width(input int fraction_bits);
        orbit_width = (fraction_bits + 8 > POINT_W) ? fraction_bits + 8 : POINT_W;
    endfunction

    // Number of multiplier slices needed to cover one orbit magnitude.
    function automatic int num_chunks(input int fraction_bits);
        num_chunks = (orbit_width(fraction_bits) + CHUNK_W - 1) / CHUNK_W;
    endfunction

endpackage

// ===== hw/rtl/mec_datapath.sv =====
// Datapath: orbit registers, shared sliced multiplier, escape test and counters.
module mec_datapath #(
    parameter int FRACTION_BITS = 28,
    parameter int LIMIT_MAX     = 65536
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [mec_pkg::CFG_W-1:0]               i_cfg_wdata,
    input  logic signed [mec_pkg::POINT_W-1:0]      i_point_real,
    input  logic signed [mec_pkg::POINT_W-1:0]      i_point_imag,
    input  mec_pkg::t_dp_cmd                        i_cmd,
    output mec_pkg::t_dp_status                     o_status,
    output logic [mec_pkg::COUNT_OUT_W-1:0]         o_escape_count
);

    localparam int ORBIT_W = mec_pkg::orbit_width(FRACTION_BITS);
    localparam int PROD_W  = 2 * ORBIT_W;
    localparam int NCHUNKS = mec_pkg::num_chunks(FRACTION_BITS);
    localparam int SLICE_W = NCHUNKS * mec_pkg::CHUNK_W;
    localparam int PP_W    = ORBIT_W + mec_pkg::CHUNK_W;
    localparam int CNT_W   = $clog2(LIMIT_MAX + 1);
    localparam int EXT_W   = (CNT_W > mec_pkg::CFG_W) ? CNT_W : mec_pkg::CFG_W;
    localparam logic [PROD_W:0] ESC_THR =
        (PROD_W + 1)'(mec_pkg::ESC_RADIUS_SQ) << (2 * FRACTION_BITS);

    // Configuration and per-point registers.
    logic [mec_pkg::CFG_W-1:0]          r_limit_cfg;
    logic [CNT_W-1:0]                   r_limit;
    logic [CNT_W-1:0]                   r_count;
    logic signed [mec_pkg::POINT_W-1:0] r_c_real;
    logic signed [mec_pkg::POINT_W-1:0] r_c_imag;
    logic signed [ORBIT_W-1:0]          r_orbit_real;
    logic signed [ORBIT_W-1:0]          r_orbit_imag;

    // Full-width products of the current orbit magnitudes.
    logic [PROD_W-1:0]                  r_prod_rr;
    logic [PROD_W-1:0]                  r_prod_ii;
    logic [PROD_W-1:0]                  r_prod_ri;
    logic [PROD_W-1:0]                  r_acc;

    // Partial product stage and its tag.
    logic [PP_W-1:0]                    r_pp;
    logic                               r_pp_valid;
    mec_pkg::t_mul_op                   r_pp_op;
    logic [mec_pkg::CHUNK_IDX_W-1:0]    r_pp_chunk;
    logic                               r_pp_first;
    logic                               r_pp_last;

    logic [mec_pkg::COUNT_OUT_W-1:0]    r_out_count;

    logic [EXT_W-1:0]                   cfg_ext;
    logic [EXT_W-1:0]                   lim_ext;
    logic [CNT_W-1:0]                   n_limit;
    logic [ORBIT_W-1:0]                 mag_real;
    logic [ORBIT_W-1:0]                 mag_imag;
    logic [ORBIT_W-1:0]                 mul_a;
    logic [ORBIT_W-1:0]                 mul_b;
    logic [SLICE_W-1:0]                 mul_b_pad;
    logic [mec_pkg::CHUNK_W-1:0]        mul_b_chunk;
    logic [PP_W-1:0]                    mul_out;
    logic [PROD_W-1:0]                  pp_shifted;
    logic [PROD_W-1:0]                  acc_sum;
    logic [PROD_W:0]                    norm;
    logic signed [PROD_W:0]             diff;
    logic signed [PROD_W:0]             diff_sh;
    logic [PROD_W:0]                    cross_mag;
    logic signed [PROD_W+1:0]           cross_prod;
    logic signed [PROD_W+1:0]           cross_sh;
    logic                               cross_neg;
    logic signed [ORBIT_W-1:0]          n_orbit_real;
    logic signed [ORBIT_W-1:0]          n_orbit_imag;
    logic [EXT_W-1:0]                   count_ext;

    // Clamp the configured limit into the range one through LIMIT_MAX.
    always_comb begin
        cfg_ext = EXT_W'(r_limit_cfg);
        if (cfg_ext == '0) begin
            lim_ext = EXT_W'(1);
        end else if (cfg_ext > EXT_W'(LIMIT_MAX)) begin
            lim_ext = EXT_W'(LIMIT_MAX);
        end else begin
            lim_ext = cfg_ext;
        end
        n_limit = CNT_W'(lim_ext);
    end

    // Magnitudes of the orbit; the most negative value maps to its unsigned magnitude.
    assign mag_real = r_orbit_real[ORBIT_W-1] ? ORBIT_W'(-r_orbit_real) : ORBIT_W'(r_orbit_real);
    assign mag_imag = r_orbit_imag[ORBIT_W-1] ? ORBIT_W'(-r_orbit_imag) : ORBIT_W'(r_orbit_imag);

    // Operand select for the shared multiplier.
    always_comb begin
        unique case (i_cmd.mul_op)
            mec_pkg::OP_RR: begin
                mul_a = mag_real;
                mul_b = mag_real;
            end
            mec_pkg::OP_II: begin
                mul_a = mag_imag;
                mul_b = mag_imag;
            end
            default: begin
                mul_a = mag_real;
                mul_b = mag_imag;
            end
        endcase
    end

    // One slice of the second operand times the whole first operand.
    assign mul_b_pad   = SLICE_W'(mul_b);
    assign mul_b_chunk = mul_b_pad[i_cmd.mul_chunk * mec_pkg::CHUNK_W +: mec_pkg::CHUNK_W];
    assign mul_out     = PP_W'(mul_a) * PP_W'(mul_b_chunk);

    // Accumulate registered partial products at their slice weight.
    assign pp_shifted = PROD_W'(r_pp) << (r_pp_chunk * mec_pkg::CHUNK_W);
    assign acc_sum    = (r_pp_first ? '0 : r_acc) + pp_shifted;

    // Escape test on the current orbit: re^2 + im^2 against four.
    assign norm = {1'b0, r_prod_rr} + {1'b0, r_prod_ii};

    always_comb begin
        o_status.escaped  = (norm >= ESC_THR);
        o_status.at_limit = (({1'b0, r_count} + (CNT_W + 1)'(1)) >= {1'b0, r_limit});
    end

    // Next orbit: products shifted down with floor rounding, then c added.
    always_comb begin
        diff         = $signed({1'b0, r_prod_rr}) - $signed({1'b0, r_prod_ii});
        diff_sh      = diff >>> FRACTION_BITS;
        cross_mag    = {r_prod_ri, 1'b0};
        cross_neg    = r_orbit_real[ORBIT_W-1] ^ r_orbit_imag[ORBIT_W-1];
        cross_prod   = cross_neg ? -$signed({1'b0, cross_mag}) : $signed({1'b0, cross_mag});
        cross_sh     = cross_prod >>> FRACTION_BITS;
        n_orbit_real = ORBIT_W'(diff_sh) + ORBIT_W'(r_c_real);
        n_orbit_imag = ORBIT_W'(cross_sh) + ORBIT_W'(r_c_imag);
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_cfg <= mec_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_limit_cfg <= i_cfg_wdata;
        end
    end

    // Point, orbit and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_orbit_real <= '0;
            r_orbit_imag <= '0;
        end else if (i_cmd.load) begin
            r_count      <= '0;
            r_orbit_real <= '0;
            r_orbit_imag <= '0;
        end else if (i_cmd.step) begin
            r_count      <= r_count + CNT_W'(1);
            r_orbit_real <= n_orbit_real;
            r_orbit_imag <= n_orbit_imag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c_real <= i_point_real;
            r_c_imag <= i_point_imag;
            r_limit  <= n_limit;
        end
    end

    // Multiplier output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid <= 1'b0;
        end else begin
            r_pp_valid <= i_cmd.mul_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_issue) begin
            r_pp       <= mul_out;
            r_pp_op    <= i_cmd.mul_op;
            r_pp_chunk <= i_cmd.mul_chunk;
            r_pp_first <= i_cmd.mul_first;
            r_pp_last  <= i_cmd.mul_last;
        end
    end

    // Accumulator and product registers; a new point starts from zero products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod_rr <= '0;
            r_prod_ii <= '0;
            r_prod_ri <= '0;
        end else if (r_pp_valid) begin
            r_acc <= acc_sum;
            if (r_pp_last) begin
                case (r_pp_op)
                    mec_pkg::OP_RR: r_prod_rr <= acc_sum;
                    mec_pkg::OP_II: r_prod_ii <= acc_sum;
                    default:        r_prod_ri <= acc_sum;
                endcase
            end
        end
    end

    // Result register; the field carries the low bits of the count.
    assign count_ext = EXT_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= count_ext[mec_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_escape_count = r_out_count;

endmodule

// ===== hw/rtl/mec_ctrl.sv =====
// Controller: sequences load, multiply slices, escape test, orbit update and result hand-off.
module mec_ctrl #(
    parameter int FRACTION_BITS = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  mec_pkg::t_dp_status  i_status,
    output mec_pkg::t_dp_cmd     o_cmd
);

    localparam int NCHUNKS = mec_pkg::num_chunks(FRACTION_BITS);
    localparam logic [mec_pkg::CHUNK_IDX_W-1:0] LAST_CHUNK =
        mec_pkg::CHUNK_IDX_W'(NCHUNKS - 1);

    mec_pkg::t_state                  r_state;
    mec_pkg::t_state                  n_state;
    mec_pkg::t_mul_op                 r_op;
    mec_pkg::t_mul_op                 n_op;
    logic [mec_pkg::CHUNK_IDX_W-1:0]  r_chunk;
    logic [mec_pkg::CHUNK_IDX_W-1:0]  n_chunk;
    logic                             r_out_valid;
    logic                             n_out_valid;

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mec_pkg::ST_IDLE;
            r_op        <= mec_pkg::OP_RR;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_chunk     <= n_chunk;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        n_op            = r_op;
        n_chunk         = r_chunk;
        o_cmd           = '0;
        o_cmd.mul_op    = r_op;
        o_cmd.mul_chunk = r_chunk;
        o_cmd.mul_first = (r_chunk == '0);
        o_cmd.mul_last  = (r_chunk == LAST_CHUNK);

        unique case (r_state)
            mec_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mec_pkg::ST_STEP;
                end
            end
            mec_pkg::ST_STEP: begin
                o_cmd.step = 1'b1;
                if (i_status.at_limit) begin
                    n_state = mec_pkg::ST_DONE;
                end else begin
                    n_state = mec_pkg::ST_MUL;
                    n_op    = mec_pkg::OP_RR;
                    n_chunk = '0;
                end
            end
            mec_pkg::ST_MUL: begin
                o_cmd.mul_issue = 1'b1;
                if (r_chunk == LAST_CHUNK) begin
                    n_chunk = '0;
                    case (r_op)
                        mec_pkg::OP_RR: n_op = mec_pkg::OP_II;
                        mec_pkg::OP_II: n_op = mec_pkg::OP_RI;
                        default:        n_state = mec_pkg::ST_TEST;
                    endcase
                end else begin
                    n_chunk = r_chunk + mec_pkg::CHUNK_IDX_W'(1);
                end
            end
            mec_pkg::ST_TEST: begin
                // The last cross-product slice settles here; the test needs only the squares.
                if (i_status.escaped) begin
                    n_state = mec_pkg::ST_DONE;
                end else begin
                    n_state = mec_pkg::ST_STEP;
                end
            end
            mec_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mec_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mec_pkg::ST_IDLE;
            end
        endcase

        // Output valid: set on load, cleared when the result is taken.
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != mec_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== hw/rtl/mandelbrot_escape_count.sv =====
// Top level of the escape-time counter: controller, datapath and interface checks.
//
// Each request carries one point c in signed fixed point with FRACTION_BITS fraction bits
// (Q4.28 by default). From z = 0 the block repeats z = z*z + c and returns how many steps
// were done when |z|^2 first reaches 4 or the count reaches iteration_limit (zero counts as
// one, values above LIMIT_MAX are held at LIMIT_MAX). Points are processed one at a time.
// One shared multiplier forms the three products re*re, im*im and re*im, each as
// ceil(orbit_width / 18) slices; the orbit is 36 bits wide by default. Each iteration runs
// an orbit step, the multiply slices and the escape test, in that order. The result is
// handed off from the done state, which waits while the output register still holds an
// unaccepted result. A finished count waits in the output register while the next
// request is already taken. Write iteration_limit only while idle.
module mandelbrot_escape_count #(
    parameter int FRACTION_BITS = 28,
    parameter int LIMIT_MAX     = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mec_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [mec_pkg::POINT_W-1:0]  i_point_real,
    input  logic signed [mec_pkg::POINT_W-1:0]  i_point_imag,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mec_pkg::COUNT_OUT_W-1:0]     o_escape_count
);

    mec_pkg::t_dp_cmd    cmd;
    mec_pkg::t_dp_status status;

    // Sequencer.
    mec_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Arithmetic and storage.
    mec_datapath #(
        .FRACTION_BITS (FRACTION_BITS),
        .LIMIT_MAX     (LIMIT_MAX)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_point_real   (i_point_real),
        .i_point_imag   (i_point_imag),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_escape_count (o_escape_count)
    );

    // An accepted request always starts with one orbit step.
    a_load_then_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.step)
        else $error("load not followed by an orbit step");

    // The block goes busy right after taking a request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a request");

    // Leaving the busy phase always presents a result.
    a_result_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_stall) && $past(i_rst_n)) |-> o_valid)
        else $error("block went idle without a result");

    // A fresh result counts at least one step.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_escape_count != '0))
        else $error("escape count of zero");

endmodule
